// ----- rtl/vrf_pkg.sv -----
`default_nettype none

package vrf_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int INDEX_WIDTH = 16;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_ZERO_INDEX = 2'd1;
    localparam status_t ST_TIR        = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/vrf_isqrt.sv -----
`default_nettype none

module vrf_isqrt
    import vrf_pkg::*;
#(
    parameter int FRAC = COMPONENT_WIDTH_DEF - 2,
    parameter int SIDE_W = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [2*FRAC:0]     radicand,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     out_valid,
    output logic [FRAC+1:0]          root,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int KW  = 2 * FRAC + 1;
    localparam int KB  = 2 * FRAC + 2;
    localparam int NS  = FRAC + 1;
    localparam int RTW = FRAC + 2;
    localparam int RMW = FRAC + 4;

    logic              st_v_reg    [NS+1];
    logic [KB-1:0]     st_k_reg    [NS+1];
    logic [RTW-1:0]    st_root_reg [NS+1];
    logic [RMW-1:0]    st_rem_reg  [NS+1];
    logic [SIDE_W-1:0] st_side_reg [NS+1];

    logic              out_v_reg;
    logic [RTW-1:0]    out_root_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic [RTW-1:0]    root_next;

    // stage zero is the input itself
    always_comb
    begin
        st_v_reg[0]    = in_valid;
        st_k_reg[0]    = {{(KB-KW){1'b0}}, radicand};
        st_root_reg[0] = '0;
        st_rem_reg[0]  = '0;
        st_side_reg[0] = side_in;
    end

    // one root bit per stage
    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic [RMW-1:0] cur;
        logic [RMW-1:0] trial;
        logic           ge;

        assign cur   = {st_rem_reg[j][RMW-3:0], st_k_reg[j][KB-1-2*j -: 2]};
        assign trial = {st_root_reg[j], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                st_v_reg[j+1] <= st_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_k_reg[j+1]    <= st_k_reg[j];
                st_rem_reg[j+1]  <= ge ? (cur - trial) : cur;
                st_root_reg[j+1] <= {st_root_reg[j][RTW-2:0], ge};
                st_side_reg[j+1] <= st_side_reg[j];
            end
        end
    end

    // round to nearest: remainder above root means the next integer is closer
    always_comb
    begin
        root_next = st_root_reg[NS];
        if (st_rem_reg[NS] > RMW'(st_root_reg[NS]))
        begin
            root_next = st_root_reg[NS] + RTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= st_v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_root_reg <= root_next;
            out_side_reg <= st_side_reg[NS];
        end
    end

    assign out_valid = out_v_reg;
    assign root      = out_root_reg;
    assign side_out  = out_side_reg;

endmodule

`default_nettype wire

// ----- rtl/vector_refract.sv -----
`default_nettype none

// Snell refraction of a unit direction about a unit normal, signed Q2.(W-2)
// components, unsigned Q4.12 indices. One transaction is taken every clock
// unless the output stalls; the pipeline depth is set by the bit-per-stage
// restoring divider for the index ratio (COMPONENT_WIDTH+17 stages) and the
// bit-per-stage square root (COMPONENT_WIDTH-1 stages). The whole pipeline
// holds while the output transaction waits, so in_ready follows out_ready. A
// zero index gives a zero vector with status 1, total internal reflection a
// zero vector with status 2.
module vector_refract
    import vrf_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COMPONENT_WIDTH-1:0] dir_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] dir_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] dir_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] norm_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] norm_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] norm_z,
    input  wire logic [INDEX_WIDTH-1:0]            index_from,
    input  wire logic [INDEX_WIDTH-1:0]            index_to,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [COMPONENT_WIDTH-1:0]      out_x,
    output logic signed [COMPONENT_WIDTH-1:0]      out_y,
    output logic signed [COMPONENT_WIDTH-1:0]      out_z,
    output logic [1:0]                             status
);

    localparam int W    = COMPONENT_WIDTH;
    localparam int F    = W - 2;
    localparam int IW   = INDEX_WIDTH;
    localparam int PRW  = 2 * W;
    localparam int CW   = W + 4;
    localparam int NW   = W + 1;
    localparam int MW   = 2 * W + 2;
    localparam int TW   = W + 2;
    localparam int PMW  = TW + IW + 1;
    localparam int MB   = W + 17;
    localparam int RW   = IW + 1;
    localparam int KW   = 2 * F + 1;
    localparam int KS   = 2 * F + 3;
    localparam int RTW  = F + 2;
    localparam int RPW  = RTW + 1 + NW;
    localparam int SIDE_W = 3 * W + 3 * NW + 2;

    localparam logic signed [PRW-1:0] HALF_P = PRW'(64'sd1 <<< (F - 1));
    localparam logic signed [MW-1:0]  HALF_M = MW'(64'sd1 <<< (F - 1));
    localparam logic signed [RPW-1:0] HALF_R = RPW'(64'sd1 <<< (F - 1));
    localparam logic signed [CW-1:0]  ONE_C  = CW'(64'sd1 <<< F);
    localparam logic [MB-1:0]         LIM_Q  = MB'(64'd1 << F);
    localparam logic [KS-1:0]         ONE_SQ = KS'(64'd1 << (2 * F));
    localparam logic signed [RPW-1:0] MAX_O  = RPW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [RPW-1:0] MIN_O  = -MAX_O - RPW'(1);

    logic en;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    logic signed [W-1:0] din [3];
    logic signed [W-1:0] nin [3];

    always_comb
    begin
        din[0] = dir_x;
        din[1] = dir_y;
        din[2] = dir_z;
        nin[0] = norm_x;
        nin[1] = norm_y;
        nin[2] = norm_z;
    end

    // ---------------------------------------------------------------- s1: d.n products
    logic                  s1_v_reg;
    logic signed [W-1:0]   s1_d_reg  [3];
    logic signed [W-1:0]   s1_n_reg  [3];
    logic signed [PRW-1:0] s1_pr_reg [3];
    logic [IW-1:0]         s1_i1_reg;
    logic [IW-1:0]         s1_i2_reg;
    status_t               s1_st_next;
    status_t               s1_st_reg;

    assign s1_st_next = (index_from == '0 || index_to == '0) ? ST_ZERO_INDEX : ST_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i]  <= din[i];
                s1_n_reg[i]  <= nin[i];
                s1_pr_reg[i] <= PRW'(din[i]) * PRW'(nin[i]);
            end
            s1_i1_reg <= index_from;
            s1_i2_reg <= index_to;
            s1_st_reg <= s1_st_next;
        end
    end

    // ---------------------------------------------------------------- s2: c, flip, clamp
    logic                s2_v_reg;
    logic signed [W-1:0] s2_d_reg [3];
    logic signed [NW-1:0] s2_n_reg [3];
    logic signed [W-1:0] s2_c_reg;
    logic [IW-1:0]       s2_i1_reg;
    logic [IW-1:0]       s2_i2_reg;
    status_t             s2_st_reg;

    logic signed [CW-1:0] c_sum;
    logic signed [CW-1:0] c_flip;
    logic signed [CW-1:0] c_clamp;
    logic                 c_pos;
    logic signed [PRW-1:0] c_rnd [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_rnd[i] = (s1_pr_reg[i] + HALF_P) >>> F;
        end
        c_sum  = CW'(c_rnd[0]) + CW'(c_rnd[1]) + CW'(c_rnd[2]);
        c_pos  = (c_sum > CW'(0));
        c_flip = c_pos ? -c_sum : c_sum;
        c_clamp = c_flip;
        if (c_flip < -ONE_C)
        begin
            c_clamp = -ONE_C;
        end
        if (c_flip > ONE_C)
        begin
            c_clamp = ONE_C;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_d_reg[i] <= s1_d_reg[i];
                s2_n_reg[i] <= c_pos ? -NW'(s1_n_reg[i]) : NW'(s1_n_reg[i]);
            end
            s2_c_reg  <= W'(c_clamp);
            s2_i1_reg <= c_pos ? s1_i2_reg : s1_i1_reg;
            s2_i2_reg <= c_pos ? s1_i1_reg : s1_i2_reg;
            s2_st_reg <= s1_st_reg;
        end
    end

    // ---------------------------------------------------------------- s3: c*n
    logic                 s3_v_reg;
    logic signed [W-1:0]  s3_d_reg [3];
    logic signed [NW-1:0] s3_n_reg [3];
    logic signed [MW-1:0] s3_m_reg [3];
    logic [IW-1:0]        s3_i1_reg;
    logic [IW-1:0]        s3_i2_reg;
    status_t              s3_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_d_reg[i] <= s2_d_reg[i];
                s3_n_reg[i] <= s2_n_reg[i];
                s3_m_reg[i] <= MW'(s2_c_reg) * MW'(s2_n_reg[i]);
            end
            s3_i1_reg <= s2_i1_reg;
            s3_i2_reg <= s2_i2_reg;
            s3_st_reg <= s2_st_reg;
        end
    end

    // ---------------------------------------------------------------- s4: t = d - c*n
    logic                 s4_v_reg;
    logic signed [TW-1:0] s4_t_reg [3];
    logic signed [NW-1:0] s4_n_reg [3];
    logic [IW-1:0]        s4_i1_reg;
    logic [IW-1:0]        s4_i2_reg;
    status_t              s4_st_reg;
    logic signed [MW-1:0] m_rnd [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_rnd[i] = (s3_m_reg[i] + HALF_M) >>> F;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_t_reg[i] <= TW'(s3_d_reg[i]) - TW'(m_rnd[i]);
                s4_n_reg[i] <= s3_n_reg[i];
            end
            s4_i1_reg <= s3_i1_reg;
            s4_i2_reg <= s3_i2_reg;
            s4_st_reg <= s3_st_reg;
        end
    end

    // ---------------------------------------------------------------- s5: t*index
    logic                  s5_v_reg;
    logic signed [PMW-1:0] s5_pr_reg [3];
    logic signed [NW-1:0]  s5_n_reg  [3];
    logic [IW-1:0]         s5_i2_reg;
    status_t               s5_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_pr_reg[i] <= PMW'(s4_t_reg[i]) * PMW'($signed({1'b0, s4_i1_reg}));
                s5_n_reg[i]  <= s4_n_reg[i];
            end
            s5_i2_reg <= s4_i2_reg;
            s5_st_reg <= s4_st_reg;
        end
    end

    // ---------------------------------------------------------------- divider, index 0 is s6
    logic                 dv_v_reg   [MB+1];
    logic [IW-1:0]        dv_den_reg [MB+1];
    status_t              dv_st_reg  [MB+1];
    logic [MB-1:0]        dv_dvd_reg [MB+1][3];
    logic [MB-1:0]        dv_q_reg   [MB+1][3];
    logic [RW-1:0]        dv_rem_reg [MB+1][3];
    logic                 dv_neg_reg [MB+1][3];
    logic signed [NW-1:0] dv_n_reg   [MB+1][3];

    logic                  s6_neg [3];
    logic signed [PMW-1:0] s6_mag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_neg[i] = s5_pr_reg[i][PMW-1];
            s6_mag[i] = s6_neg[i] ? -s5_pr_reg[i] : s5_pr_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_dvd_reg[0][i] <= MB'(s6_mag[i]) + MB'(s5_i2_reg >> 1);
                dv_q_reg[0][i]   <= '0;
                dv_rem_reg[0][i] <= '0;
                dv_neg_reg[0][i] <= s6_neg[i];
                dv_n_reg[0][i]   <= s5_n_reg[i];
            end
            dv_den_reg[0] <= s5_i2_reg;
            dv_st_reg[0]  <= s5_st_reg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < MB; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_den_reg[k+1] <= dv_den_reg[k];
                dv_st_reg[k+1]  <= dv_st_reg[k];
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [RW-1:0] trial;
            logic          ge;

            assign trial = {dv_rem_reg[k][i][RW-2:0], dv_dvd_reg[k][i][MB-1-k]};
            assign ge    = (trial >= {1'b0, dv_den_reg[k]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[k+1][i] <= ge ? (trial - {1'b0, dv_den_reg[k]}) : trial;
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][MB-2:0], ge};
                    dv_dvd_reg[k+1][i] <= dv_dvd_reg[k][i];
                    dv_neg_reg[k+1][i] <= dv_neg_reg[k][i];
                    dv_n_reg[k+1][i]   <= dv_n_reg[k][i];
                end
            end
        end
    end

    // ---------------------------------------------------------------- sp: sign, range check
    logic                 sp_v_reg;
    logic signed [W-1:0]  sp_p_reg [3];
    logic signed [NW-1:0] sp_n_reg [3];
    status_t              sp_st_reg;
    status_t              sp_st_next;
    logic                 q_big [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_big[i] = (dv_q_reg[MB][i] > LIM_Q);
        end
        sp_st_next = dv_st_reg[MB];
        if (dv_st_reg[MB] == ST_OK && (q_big[0] || q_big[1] || q_big[2]))
        begin
            sp_st_next = ST_TIR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sp_v_reg <= dv_v_reg[MB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sp_p_reg[i] <= dv_neg_reg[MB][i] ? -W'(dv_q_reg[MB][i]) : W'(dv_q_reg[MB][i]);
                sp_n_reg[i] <= dv_n_reg[MB][i];
            end
            sp_st_reg <= sp_st_next;
        end
    end

    // ---------------------------------------------------------------- sq: squares
    logic                 sq_v_reg;
    logic [KW-1:0]        sq_sq_reg [3];
    logic signed [W-1:0]  sq_p_reg  [3];
    logic signed [NW-1:0] sq_n_reg  [3];
    status_t              sq_st_reg;
    logic signed [PRW-1:0] p_sq [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_sq[i] = PRW'(sp_p_reg[i]) * PRW'(sp_p_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg <= sp_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_sq_reg[i] <= KW'(p_sq[i]);
                sq_p_reg[i]  <= sp_p_reg[i];
                sq_n_reg[i]  <= sp_n_reg[i];
            end
            sq_st_reg <= sp_st_reg;
        end
    end

    // ---------------------------------------------------------------- sk: k = 1 - |p|^2
    logic                 sk_v_reg;
    logic [KW-1:0]        sk_k_reg;
    logic [SIDE_W-1:0]    sk_side_reg;
    logic [KS-1:0]        sq_sum;
    status_t              sk_st_next;
    logic [KW-1:0]        sk_k_next;

    always_comb
    begin
        sq_sum = KS'(sq_sq_reg[0]) + KS'(sq_sq_reg[1]) + KS'(sq_sq_reg[2]);
        sk_st_next = sq_st_reg;
        sk_k_next  = KW'(ONE_SQ - sq_sum);
        if (sq_sum > ONE_SQ)
        begin
            sk_k_next = '0;
            if (sq_st_reg == ST_OK)
            begin
                sk_st_next = ST_TIR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sk_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sk_k_reg    <= sk_k_next;
            sk_side_reg <= {sq_p_reg[0], sq_p_reg[1], sq_p_reg[2],
                            sq_n_reg[0], sq_n_reg[1], sq_n_reg[2], sk_st_next};
        end
    end

    // ---------------------------------------------------------------- square root
    logic              rt_v;
    logic [RTW-1:0]    rt_root;
    logic [SIDE_W-1:0] rt_side;

    vrf_isqrt #(
        .FRAC   (F),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sk_v_reg),
        .radicand  (sk_k_reg),
        .side_in   (sk_side_reg),
        .out_valid (rt_v),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    logic signed [W-1:0]  rt_p [3];
    logic signed [NW-1:0] rt_n [3];
    status_t              rt_st;

    assign {rt_p[0], rt_p[1], rt_p[2], rt_n[0], rt_n[1], rt_n[2], rt_st} = rt_side;

    // ---------------------------------------------------------------- sr: root*n
    logic                  sr_v_reg;
    logic signed [RPW-1:0] sr_rn_reg [3];
    logic signed [W-1:0]   sr_p_reg  [3];
    status_t               sr_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sr_v_reg <= rt_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sr_rn_reg[i] <= RPW'($signed({1'b0, rt_root})) * RPW'(rt_n[i]);
                sr_p_reg[i]  <= rt_p[i];
            end
            sr_st_reg <= rt_st;
        end
    end

    // ---------------------------------------------------------------- output register
    logic                  out_v_reg;
    logic signed [W-1:0]   out_c_reg [3];
    status_t               out_st_reg;
    logic signed [W-1:0]   out_c_next [3];
    logic signed [RPW-1:0] o_rnd [3];
    logic signed [RPW-1:0] o_raw [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_rnd[i] = (sr_rn_reg[i] + HALF_R) >>> F;
            o_raw[i] = RPW'(sr_p_reg[i]) - o_rnd[i];
            if (sr_st_reg != ST_OK)
            begin
                out_c_next[i] = '0;
            end
            else if (o_raw[i] > MAX_O)
            begin
                out_c_next[i] = W'(MAX_O);
            end
            else if (o_raw[i] < MIN_O)
            begin
                out_c_next[i] = W'(MIN_O);
            end
            else
            begin
                out_c_next[i] = W'(o_raw[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= sr_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_c_reg[i] <= out_c_next[i];
            end
            out_st_reg <= sr_st_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_x     = out_c_reg[0];
    assign out_y     = out_c_reg[1];
    assign out_z     = out_c_reg[2];
    assign status    = out_st_reg;

endmodule

`default_nettype wire

// ----- rtl/vrf_checker.sv -----
`default_nettype none

module vrf_checker
    import vrf_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [COMPONENT_WIDTH-1:0] out_x,
    input wire logic signed [COMPONENT_WIDTH-1:0] out_y,
    input wire logic signed [COMPONENT_WIDTH-1:0] out_z,
    input wire logic [1:0]                        status
);

    // failed transactions carry a zero vector
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("non-zero vector on failed transaction");

    // input side never blocked while the output is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(status))
        else $error("stalled result changed");

    // pipeline starts empty: nothing leaves right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present out of reset");

endmodule

bind vector_refract vrf_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_vrf_checker (.*);

`default_nettype wire
